FILE: rtl/mhc_pkg.sv
// Shared types, constants and tables for the magnetometer heading calibration block.
`timescale 1ns / 1ps

package mhc_pkg;

    // Iterations of the vectoring CORDIC (legal range 10 to 24)
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_DEPTH       = 24;
    localparam int ATAN_IDX_W       = 5;

    // Datapath widths: differences need 17 bits, CORDIC gain grows them to under 2^18
    localparam int COR_W  = 20;
    localparam int ANG_W  = 32;
    localparam int HEAD_W = 12;
    localparam int SUM_W  = 14;

    localparam logic [HEAD_W-1:0] TENTHS_FULL = 12'd3600;

    localparam logic [15:0] MIN_SAMPLES_RST = 16'd50;
    localparam logic [15:0] COUNT_MAX       = 16'hFFFF;

    // Binary angles, 2^32 per turn
    localparam logic [ANG_W-1:0] ANG_0   = 32'h0000_0000;
    localparam logic [ANG_W-1:0] ANG_90  = 32'h4000_0000;
    localparam logic [ANG_W-1:0] ANG_180 = 32'h8000_0000;
    localparam logic [ANG_W-1:0] ANG_270 = 32'hC000_0000;

    // atan(2^-i) as binary angles
    localparam logic [ANG_W-1:0] ATAN_TAB [ATAN_DEPTH] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_START  = 2'd1,
        OP_STOP   = 2'd2,
        OP_SAVE   = 2'd3
    } op_t;

    typedef enum logic {
        REG_MOUNT_OFFSET = 1'b0,
        REG_MIN_SAMPLES  = 1'b1
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_ROTATE,
        ST_SCALE,
        ST_WRAP
    } state_t;

    typedef struct packed {
        op_t                op;
        logic signed [15:0] sample_x;
        logic signed [15:0] sample_y;
    } cmd_t;

    typedef struct packed {
        logic [HEAD_W-1:0]  heading_tenths;
        logic               cal_active;
        logic [15:0]        cal_count;
        logic signed [15:0] offset_x;
        logic signed [15:0] offset_y;
        logic               offsets_updated;
    } result_t;

    typedef struct packed {
        logic signed [12:0] mount_offset_tenths;
        logic [15:0]        min_samples;
    } cfg_t;

    typedef struct packed {
        logic update;
        logic prep;
        logic rotate;
        logic scale;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic axis_case;
        logic last_step;
    } dp_status_t;

endpackage

FILE: rtl/mhc_regs.sv
// Configuration register file behind the APB-style port.
`timescale 1ns / 1ps

module mhc_regs
    import mhc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    logic signed [12:0] mount_reg;
    logic [15:0]        min_samples_reg;
    logic               wr_en;
    reg_idx_t           idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = reg_idx_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mount_reg       <= '0;
            min_samples_reg <= MIN_SAMPLES_RST;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_MOUNT_OFFSET: mount_reg       <= pwdata[12:0];
                REG_MIN_SAMPLES:  min_samples_reg <= pwdata[15:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_MOUNT_OFFSET: prdata = 32'(mount_reg);
            REG_MIN_SAMPLES:  prdata = {16'b0, min_samples_reg};
            default:          prdata = '0;
        endcase
    end

    assign cfg.mount_offset_tenths = mount_reg;
    assign cfg.min_samples         = min_samples_reg;

endmodule

FILE: rtl/mhc_ctrl.sv
// Sequencing state machine: accept, prepare, CORDIC iterations (skipped on an axis), scale, wrap and output.
`timescale 1ns / 1ps

module mhc_ctrl
    import mhc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    output logic       cmd_ready,
    output logic       heading_valid,
    input  logic       heading_ready,
    input  dp_status_t status,
    output dp_cmd_t    command
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || heading_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (cmd_valid) state_next = ST_PREP;
            ST_PREP:   state_next = status.axis_case ? ST_SCALE : ST_ROTATE;
            ST_ROTATE: if (status.last_step) state_next = ST_SCALE;
            ST_SCALE:  state_next = ST_WRAP;
            ST_WRAP:   if (slot_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd_ready        = 1'b0;
        command          = '0;
        out_valid_next   = out_valid_reg && !heading_ready;
        case (state_reg)
            ST_IDLE:
            begin
                cmd_ready      = 1'b1;
                command.update = cmd_valid;
            end
            ST_PREP:   command.prep   = 1'b1;
            ST_ROTATE: command.rotate = 1'b1;
            ST_SCALE:  command.scale  = 1'b1;
            ST_WRAP:
            begin
                command.load_out = slot_free;
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                end
            end
            default:   ;
        endcase
    end

    assign heading_valid = out_valid_reg;

endmodule

FILE: rtl/mhc_dpath.sv
// Calibration state, iterative CORDIC, tenths scaling, wrap and result register.
`timescale 1ns / 1ps

module mhc_dpath
    import mhc_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       cmd,
    input  cfg_t       cfg,
    input  dp_cmd_t    command,
    output dp_status_t status,
    output result_t    heading
);

    localparam int STEP_W = $clog2(CORDIC_STEPS);

    // Calibration state
    logic signed [15:0] last_x_reg, last_y_reg;
    logic signed [15:0] off_x_reg, off_y_reg;
    logic signed [15:0] min_x_reg, max_x_reg, min_y_reg, max_y_reg;
    logic [15:0]        count_reg;
    logic               collecting_reg;
    logic               updated_reg;

    // CORDIC and scaling
    logic signed [COR_W-1:0] x_reg, y_reg;
    logic [ANG_W-1:0]        z_reg;
    logic [STEP_W-1:0]       step_reg;
    logic [HEAD_W-1:0]       tenths_reg;
    result_t                 res_reg;

    logic signed [16:0]      sum_x, sum_y, adj_x, adj_y;
    logic signed [COR_W-1:0] dx, dy, dy_raw;
    logic                    dx_zero, dy_zero;
    logic [ANG_W-1:0]        axis_ang;
    logic [ATAN_IDX_W-1:0]   atan_idx;
    logic signed [COR_W-1:0] x_shift, y_shift;
    logic [ANG_W+HEAD_W-1:0] product;
    logic signed [SUM_W-1:0] head_sum, wrapped;
    logic                    save_ok;

    // Midpoints, halved toward zero
    assign sum_x = 17'(min_x_reg) + 17'(max_x_reg);
    assign sum_y = 17'(min_y_reg) + 17'(max_y_reg);
    assign adj_x = sum_x + $signed({16'b0, sum_x[16]});
    assign adj_y = sum_y + $signed({16'b0, sum_y[16]});
    assign save_ok = count_reg > cfg.min_samples;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_x_reg     <= '0;
            last_y_reg     <= '0;
            off_x_reg      <= '0;
            off_y_reg      <= '0;
            count_reg      <= '0;
            collecting_reg <= 1'b0;
            updated_reg    <= 1'b0;
        end
        else if (command.update)
        begin
            updated_reg <= 1'b0;
            case (cmd.op)
                OP_SAMPLE:
                begin
                    last_x_reg <= cmd.sample_x;
                    last_y_reg <= cmd.sample_y;
                    if (collecting_reg && count_reg != COUNT_MAX)
                    begin
                        count_reg <= count_reg + 16'd1;
                    end
                end
                OP_START:
                begin
                    collecting_reg <= 1'b1;
                    count_reg      <= '0;
                end
                OP_STOP:
                begin
                    collecting_reg <= 1'b0;
                end
                OP_SAVE:
                begin
                    collecting_reg <= 1'b0;
                    if (save_ok)
                    begin
                        off_x_reg   <= adj_x[16:1];
                        off_y_reg   <= adj_y[16:1];
                        updated_reg <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Extrema: first sample of a run seeds them
    always_ff @(posedge clk)
    begin
        if (command.update && cmd.op == OP_SAMPLE && collecting_reg)
        begin
            if (count_reg == '0 || cmd.sample_x < min_x_reg) min_x_reg <= cmd.sample_x;
            if (count_reg == '0 || cmd.sample_x > max_x_reg) max_x_reg <= cmd.sample_x;
            if (count_reg == '0 || cmd.sample_y < min_y_reg) min_y_reg <= cmd.sample_y;
            if (count_reg == '0 || cmd.sample_y > max_y_reg) max_y_reg <= cmd.sample_y;
        end
    end

    // Vector setup and on-axis angles
    assign dx      = COR_W'(last_x_reg) - COR_W'(off_x_reg);
    assign dy_raw  = COR_W'(last_y_reg) - COR_W'(off_y_reg);
    assign dy      = -dy_raw;
    assign dx_zero = dx == '0;
    assign dy_zero = dy == '0;

    always_comb
    begin
        if (dy_zero)
        begin
            axis_ang = (dx[COR_W-1] && !dx_zero) ? ANG_180 : ANG_0;
        end
        else
        begin
            axis_ang = dy[COR_W-1] ? ANG_270 : ANG_90;
        end
    end

    assign status.axis_case = dx_zero || dy_zero;
    assign status.last_step = step_reg == STEP_W'(CORDIC_STEPS - 1);

    assign atan_idx = ATAN_IDX_W'(step_reg);
    assign x_shift  = x_reg >>> step_reg;
    assign y_shift  = y_reg >>> step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
        end
        else if (command.prep)
        begin
            step_reg <= '0;
        end
        else if (command.rotate)
        begin
            step_reg <= step_reg + STEP_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (command.prep)
        begin
            if (status.axis_case)
            begin
                z_reg <= axis_ang;
            end
            else if (dx[COR_W-1])
            begin
                // Pre-rotate by half a turn into the right half plane
                x_reg <= -dx;
                y_reg <= -dy;
                z_reg <= ANG_180;
            end
            else
            begin
                x_reg <= dx;
                y_reg <= dy;
                z_reg <= ANG_0;
            end
        end
        else if (command.rotate)
        begin
            if (!y_reg[COR_W-1])
            begin
                x_reg <= x_reg + y_shift;
                y_reg <= y_reg - x_shift;
                z_reg <= z_reg + ATAN_TAB[atan_idx];
            end
            else
            begin
                x_reg <= x_reg - y_shift;
                y_reg <= y_reg + x_shift;
                z_reg <= z_reg - ATAN_TAB[atan_idx];
            end
        end
    end

    // Binary angle to tenths of a degree
    assign product = {{HEAD_W{1'b0}}, z_reg} * {{ANG_W{1'b0}}, TENTHS_FULL};

    always_ff @(posedge clk)
    begin
        if (command.scale)
        begin
            tenths_reg <= product[ANG_W+HEAD_W-1:ANG_W];
        end
    end

    // Add mount offset and wrap into one turn
    assign head_sum = $signed({2'b00, tenths_reg}) + SUM_W'(cfg.mount_offset_tenths);

    always_comb
    begin
        if (head_sum >= $signed({1'b0, TENTHS_FULL, 1'b0}))
        begin
            wrapped = head_sum - $signed({1'b0, TENTHS_FULL, 1'b0});
        end
        else if (head_sum >= $signed({2'b00, TENTHS_FULL}))
        begin
            wrapped = head_sum - $signed({2'b00, TENTHS_FULL});
        end
        else if (head_sum < -$signed({2'b00, TENTHS_FULL}))
        begin
            wrapped = head_sum + $signed({1'b0, TENTHS_FULL, 1'b0});
        end
        else if (head_sum[SUM_W-1])
        begin
            wrapped = head_sum + $signed({2'b00, TENTHS_FULL});
        end
        else
        begin
            wrapped = head_sum;
        end
    end

    always_ff @(posedge clk)
    begin
        if (command.load_out)
        begin
            res_reg.heading_tenths  <= wrapped[HEAD_W-1:0];
            res_reg.cal_active      <= collecting_reg;
            res_reg.cal_count       <= count_reg;
            res_reg.offset_x        <= off_x_reg;
            res_reg.offset_y        <= off_y_reg;
            res_reg.offsets_updated <= updated_reg;
        end
    end

    assign heading = res_reg;

endmodule

FILE: rtl/magnetometer_heading_calibration.sv
// Magnetometer heading with hard-iron calibration: top level.
// A result passes setup, CORDIC rotation (skipped on an axis), scaling and wrap before it is valid.
// A new transaction is taken only once the last one has left its wrap stage; the iterative CORDIC
// rotates once per cycle, and a waiting result holds the next item in its
// wrap stage until the output register drains.
// Reset: rst_n is asynchronous, active low; clears offsets, count, calibration flag and
// the output valid, and loads mount offset 0 and min_samples 50.
`timescale 1ns / 1ps

module magnetometer_heading_calibration
    import mhc_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,

    // Command and sample transactions
    input  logic        cmd_valid,
    output logic        cmd_ready,
    input  cmd_t        cmd,

    // Heading result transactions
    output logic        heading_valid,
    input  logic        heading_ready,
    output result_t     heading,

    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t       cfg;
    dp_cmd_t    command;
    dp_status_t status;

    // Register file: mount offset at 0x0, minimum sample count at 0x4
    mhc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Controller: takes one transaction at a time while idle, steps the datapath
    // through setup, rotation (skipped on an axis), scaling and wrap, then hands the result to the
    // output register as soon as that register is free or being drained.
    mhc_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_valid),
        .cmd_ready     (cmd_ready),
        .heading_valid (heading_valid),
        .heading_ready (heading_ready),
        .status        (status),
        .command       (command)
    );

    // Datapath: calibration tracking, vectoring CORDIC, tenths scaling, offset wrap and the
    // result register that decouples the output side.
    mhc_dpath #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_dpath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .cfg     (cfg),
        .command (command),
        .status  (status),
        .heading (heading)
    );

endmodule
